[hdl/srf_pkg.sv]
// ----------------------------------------------------------------------------
// srf_pkg
// Shared types and constants for the sliding window rank filter.
// ----------------------------------------------------------------------------
package srf_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // Configuration register file.
    localparam int CFG_BITS   = 7;
    localparam int LEN_RESET  = 5;
    localparam int RANK_RESET = 3;

    typedef enum logic
    {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_RANK_FROM_TOP = 1'b1
    } cfg_index_t;

    // Status one cell hands to the cell below it.
    typedef struct packed
    {
        logic gt;    // new sample is above this cell's entry
        logic seen;  // the entry being retired sits at or above this cell
    } link_t;

endpackage

[hdl/sliding_window_rank_filter.sv]
// ----------------------------------------------------------------------------
// sliding_window_rank_filter
// Running order statistic over the most recent samples of a stream.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while in_stall is low and returns via
// its output register the selected rank of the window that includes it. The
// window is kept sorted in a row of WINDOW_MAX cells, each holding one sample
// and its age; every cell compares the new sample with its own entry once, and
// the position of the retiring sample ripples down the row, which sets the
// clock period. Writing window_length restarts the window with zero samples.
// ----------------------------------------------------------------------------
module sliding_window_rank_filter #(
    parameter int WINDOW_MAX  = srf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = srf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [SAMPLE_BITS-1:0]    ranked_value,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic        [srf_pkg::CFG_BITS-1:0] cfg_wdata
);

    localparam int AGE_BITS     = $clog2(WINDOW_MAX);
    localparam int RESET_LEN    = (srf_pkg::LEN_RESET > WINDOW_MAX) ?
                                  WINDOW_MAX : srf_pkg::LEN_RESET;
    localparam int RESET_LEN_M1 = RESET_LEN - 1;

    logic                          accept;
    logic                          load;
    logic                          pending_reg;
    logic                          pending_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] ranked_reg;
    logic signed [SAMPLE_BITS-1:0] ranked_next;
    logic [AGE_BITS-1:0]           len_m1_reg;
    logic [AGE_BITS-1:0]           len_m1_next;
    logic [srf_pkg::CFG_BITS-1:0]  rank_reg;
    logic [srf_pkg::CFG_BITS-1:0]  rank_next;
    logic [srf_pkg::CFG_BITS-1:0]  rank_raw_m1;
    logic [AGE_BITS-1:0]           rank_m1;
    logic [AGE_BITS-1:0]           sel_index;
    logic                          clear;

    logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
    logic        [AGE_BITS-1:0]    cell_age   [WINDOW_MAX];
    srf_pkg::link_t                cell_link  [WINDOW_MAX];

    always_comb
    begin
        clear       = cfg_we && (cfg_index == srf_pkg::CFG_WINDOW_LENGTH);
        len_m1_next = len_m1_reg;
        rank_next   = rank_reg;
        if (clear)
        begin
            if (cfg_wdata == '0)
                len_m1_next = '0;
            else if (int'(cfg_wdata) > WINDOW_MAX)
                len_m1_next = AGE_BITS'(WINDOW_MAX - 1);
            else
                len_m1_next = AGE_BITS'(int'(cfg_wdata) - 1);
        end
        if (cfg_we && (cfg_index == srf_pkg::CFG_RANK_FROM_TOP))
            rank_next = cfg_wdata;

        rank_raw_m1 = (rank_reg == '0) ? '0 : rank_reg - 1'b1;
        if (int'(rank_raw_m1) > int'(len_m1_reg))
            rank_m1 = len_m1_reg;
        else
            rank_m1 = AGE_BITS'(rank_raw_m1);

        // The row is sorted with the smallest entry in the first cell, so the
        // rank counted from the top sits that far up from the last active cell.
        sel_index = len_m1_reg - rank_m1;

        // The output register reads the cells after they update, once it is free.
        load           = pending_reg && (!out_valid_reg || !out_stall);
        in_stall       = pending_reg && out_valid_reg && out_stall;
        accept         = in_valid && !in_stall;
        pending_next   = accept || (pending_reg && !load);
        out_valid_next = load || (out_valid_reg && out_stall);
        ranked_next    = load ? cell_value[sel_index] : ranked_reg;
    end

    generate
        for (genvar i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            logic signed [SAMPLE_BITS-1:0] up_value;
            logic        [AGE_BITS-1:0]    up_age;
            srf_pkg::link_t                up_link;
            logic signed [SAMPLE_BITS-1:0] dn_value;
            logic        [AGE_BITS-1:0]    dn_age;
            logic                          dn_gt;

            if (i == 0)
            begin : g_top
                // Nothing sits above the first cell, so the sample can
                // always go in there.
                assign up_value     = '0;
                assign up_age       = '0;
                assign up_link.gt   = 1'b1;
                assign up_link.seen = 1'b0;
            end
            else
            begin : g_mid
                assign up_value = cell_value[i-1];
                assign up_age   = cell_age[i-1];
                assign up_link  = cell_link[i-1];
            end

            if (i == WINDOW_MAX - 1)
            begin : g_end
                assign dn_value = '0;
                assign dn_age   = '0;
                assign dn_gt    = 1'b0;
            end
            else
            begin : g_next
                assign dn_value = cell_value[i+1];
                assign dn_age   = cell_age[i+1];
                assign dn_gt    = cell_link[i+1].gt;
            end

            srf_cell #(
                .SAMPLE_BITS  (SAMPLE_BITS),
                .AGE_BITS     (AGE_BITS),
                .INDEX        (i),
                .RESET_LEN_M1 (RESET_LEN_M1)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .shift        (accept),
                .clear        (clear),
                .sample       (sample),
                .len_m1       (len_m1_reg),
                .clear_len_m1 (len_m1_next),
                .up_value     (up_value),
                .up_age       (up_age),
                .up_link      (up_link),
                .dn_value     (dn_value),
                .dn_age       (dn_age),
                .dn_gt        (dn_gt),
                .value        (cell_value[i]),
                .age          (cell_age[i]),
                .link         (cell_link[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            len_m1_reg    <= AGE_BITS'(RESET_LEN_M1);
            rank_reg      <= srf_pkg::CFG_BITS'(srf_pkg::RANK_RESET);
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            len_m1_reg    <= len_m1_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ranked_reg <= ranked_next;
    end

    assign out_valid    = out_valid_reg;
    assign ranked_value = ranked_reg;

endmodule

[hdl/srf_cell.sv]
// ----------------------------------------------------------------------------
// srf_cell
// One position of the sorted window: holds an entry and its age, and picks
// its next entry from itself, its neighbors or the new sample.
// ----------------------------------------------------------------------------
module srf_cell #(
    parameter int SAMPLE_BITS  = srf_pkg::SAMPLE_BITS_DEF,
    parameter int AGE_BITS     = 6,
    parameter int INDEX        = 0,
    parameter int RESET_LEN_M1 = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  logic                          clear,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [AGE_BITS-1:0]    len_m1,
    input  logic        [AGE_BITS-1:0]    clear_len_m1,
    input  logic signed [SAMPLE_BITS-1:0] up_value,
    input  logic        [AGE_BITS-1:0]    up_age,
    input  srf_pkg::link_t                up_link,
    input  logic signed [SAMPLE_BITS-1:0] dn_value,
    input  logic        [AGE_BITS-1:0]    dn_age,
    input  logic                          dn_gt,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic        [AGE_BITS-1:0]    age,
    output srf_pkg::link_t                link
);

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic        [AGE_BITS-1:0]    age_reg;
    logic        [AGE_BITS-1:0]    age_next;
    logic                          active;
    logic                          last;
    logic                          retire;
    logic                          gt;
    logic                          keep_here;
    logic                          take_new;

    always_comb
    begin
        active = int'(len_m1) >= INDEX;
        last   = int'(len_m1) == INDEX;
        retire = active && (age_reg == len_m1);
        gt     = sample > value_reg;

        link.gt   = gt;
        link.seen = up_link.seen || retire;

        // With the retired entry squeezed out, position i holds this entry
        // above the retired one and the lower neighbor's entry below it.
        keep_here = last ? 1'b0 : (link.seen ? dn_gt : gt);
        take_new  = up_link.seen ? gt : up_link.gt;

        value_next = value_reg;
        age_next   = age_reg;
        if (clear)
        begin
            value_next = '0;
            age_next   = clear_len_m1 - AGE_BITS'(INDEX);
        end
        else if (shift && active)
        begin
            if (keep_here)
            begin
                value_next = link.seen ? dn_value : value_reg;
                age_next   = (link.seen ? dn_age : age_reg) + 1'b1;
            end
            else if (take_new)
            begin
                value_next = sample;
                age_next   = '0;
            end
            else
            begin
                value_next = up_link.seen ? value_reg : up_value;
                age_next   = (up_link.seen ? age_reg : up_age) + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            age_reg   <= AGE_BITS'(RESET_LEN_M1 - INDEX);
        end
        else
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;

endmodule

[hdl/srf_checker.sv]
// ----------------------------------------------------------------------------
// srf_checker
// Port-level checks of the rank filter, bound to the top level.
// ----------------------------------------------------------------------------
module srf_checker #(
    parameter int SAMPLE_BITS = srf_pkg::SAMPLE_BITS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic        [SAMPLE_BITS-1:0]    sample,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic        [SAMPLE_BITS-1:0]    ranked_value
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ranked_value))
    else $error("stalled result changed");

    // A result leaves only when it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without being taken");

    // The input is held off only when a result already waits downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

    // Every accepted request is followed by a valid result at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 out_valid)
    else $error("no result after an accepted request");

    // A stalled request keeps its sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(sample))
    else $error("stalled request changed");

endmodule

bind sliding_window_rank_filter srf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_srf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ranked_value (ranked_value)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window rank filter. Samples go in over
// the request channel while a local window model predicts every ranked
// result; results are compared in order as they leave the block. The run
// covers the register extremes and random streams under varied idling.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_MAX     = srf_pkg::WINDOW_MAX_DEF;
    localparam int SAMPLE_BITS    = srf_pkg::SAMPLE_BITS_DEF;
    localparam int LATENCY        = 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_SET  = 110;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    sample_t                      sample;
    logic                         out_valid;
    logic                         out_stall;
    sample_t                      ranked_value;
    logic                         cfg_we;
    logic                         cfg_index;
    logic [srf_pkg::CFG_BITS-1:0] cfg_wdata;

    // Window model: sample per slot, next slot to overwrite, register copies.
    sample_t                      window_hist [WINDOW_MAX];
    int                           next_slot;
    logic [srf_pkg::CFG_BITS-1:0] len_setting;
    logic [srf_pkg::CFG_BITS-1:0] rank_setting;

    sample_t expected_ranked [$];
    sample_t oldest_expect;
    sample_t last_sent;

    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    int mismatch_count;
    int samples_sent;
    int results_checked;
    int settings_used;

    sliding_window_rank_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ranked_value (ranked_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void restart_window();
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            window_hist[i] = '0;
        end
        next_slot = 0;
    endfunction

    // Stores the sample in the oldest slot and returns the selected rank of
    // the window. Ties need no order: any member of a tied group is the value.
    function automatic sample_t insert_and_rank(input sample_t s);
        int      len;
        int      rk;
        int      above_cnt;
        int      tie_cnt;
        sample_t pick;
        len = (len_setting < 1) ? 1 : (len_setting > WINDOW_MAX) ? WINDOW_MAX : len_setting;
        rk  = (rank_setting < 1) ? 1 : (rank_setting > len) ? len : rank_setting;
        if (next_slot >= len)
        begin
            next_slot = 0;
        end
        window_hist[next_slot] = s;
        next_slot = (next_slot + 1 >= len) ? 0 : next_slot + 1;
        pick = '0;
        for (int i = 0; i < len; i++)
        begin
            above_cnt = 0;
            tie_cnt   = 0;
            for (int j = 0; j < len; j++)
            begin
                if (window_hist[j] > window_hist[i])
                begin
                    above_cnt++;
                end
                else if (window_hist[j] == window_hist[i])
                begin
                    tie_cnt++;
                end
            end
            if (above_cnt < rk && above_cnt + tie_cnt >= rk)
            begin
                pick = window_hist[i];
            end
        end
        return pick;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // Called and returning at a falling edge.
    task automatic send_sample(input sample_t s);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample   = s;
        expected_ranked.push_back(insert_and_rank(s));
        last_sent = s;
        samples_sent++;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (expected_ranked.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_reg(input srf_pkg::cfg_index_t idx,
                             input logic [srf_pkg::CFG_BITS-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == srf_pkg::CFG_WINDOW_LENGTH)
        begin
            len_setting = val;
            restart_window();
        end
        else
        begin
            rank_setting = val;
        end
        settings_used++;
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        case ($urandom_range(9))
            5, 6:    s = $signed($urandom_range(8)) - 4;
            7:       s = $urandom_range(1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                           : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            8:       s = ($signed($urandom_range(31)) - 16) <<< 16;
            9:       s = last_sent;
            default: s = $urandom;
        endcase
        return s;
    endfunction

    task automatic set_idle_mode(input int mode);
        case (mode)
            1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
            3:       begin send_idle_pct = 10; recv_stall_pct = 10; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Reset values, sample extremes and runs of equal samples.
    task automatic test_reset_defaults();
        send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        send_sample(-1);
        send_sample(1);
        send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        send_sample(32'sh0001_0000);
        send_sample(-32'sh0001_0000);
        settle();
    endtask

    // Zero and oversized register values saturate.
    task automatic test_register_saturation();
        write_reg(srf_pkg::CFG_WINDOW_LENGTH, '0);
        write_reg(srf_pkg::CFG_RANK_FROM_TOP, '0);
        send_sample(-7);
        send_sample(9);
        send_sample(9);
        settle();
        write_reg(srf_pkg::CFG_WINDOW_LENGTH, '1);
        write_reg(srf_pkg::CFG_RANK_FROM_TOP, '1);
        send_sample(-3);
        send_sample(-5);
        send_sample(12);
        settle();
        write_reg(srf_pkg::CFG_RANK_FROM_TOP, 7'd1);
        send_sample(-2);
        send_sample(4);
        settle();
    endtask

    // A rank write changes the selection but keeps the window contents.
    task automatic test_rank_keeps_window();
        write_reg(srf_pkg::CFG_WINDOW_LENGTH, 7'd4);
        write_reg(srf_pkg::CFG_RANK_FROM_TOP, 7'd2);
        send_sample(40);
        send_sample(-10);
        send_sample(25);
        settle();
        write_reg(srf_pkg::CFG_RANK_FROM_TOP, 7'd4);
        send_sample(3);
        send_sample(60);
        settle();
    endtask

    task automatic test_random_streams();
        logic [srf_pkg::CFG_BITS-1:0] len_pick  [10];
        logic [srf_pkg::CFG_BITS-1:0] rank_pick [10];
        int                           sel;
        len_pick  = '{7'd64, 7'd1, 7'd5, 7'd64, 7'd7, 7'd0, 7'd33, 7'd127, 7'd2, 7'd64};
        rank_pick = '{7'd32, 7'd1, 7'd3, 7'd64, 7'd127, 7'd0, 7'd17, 7'd5, 7'd2, 7'd1};
        for (int mode = 0; mode < 4; mode++)
        begin
            set_idle_mode(mode);
            for (int k = 0; k < 4; k++)
            begin
                sel = (mode * 4 + k) % 10;
                // Every fourth set keeps the previous window and only moves the rank.
                if (k != 2)
                begin
                    write_reg(srf_pkg::CFG_WINDOW_LENGTH, len_pick[sel]);
                end
                write_reg(srf_pkg::CFG_RANK_FROM_TOP, rank_pick[sel]);
                for (int n = 0; n < ITEMS_PER_SET; n++)
                begin
                    send_sample(random_sample());
                end
                settle();
            end
        end
        set_idle_mode(0);
    endtask

    always @(negedge clk)
    begin
        out_stall = rst_n && recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ranked.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no request pending", ranked_value));
            end
            else
            begin
                oldest_expect = expected_ranked.pop_front();
                results_checked++;
                if (ranked_value !== oldest_expect)
                begin
                    report_mismatch($sformatf("ranked_value %0d, expected %0d",
                                              ranked_value, oldest_expect));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        sample          = '0;
        out_stall       = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = srf_pkg::CFG_WINDOW_LENGTH;
        cfg_wdata       = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        idle_cycles     = 0;
        mismatch_count  = 0;
        samples_sent    = 0;
        results_checked = 0;
        settings_used   = 0;
        last_sent       = '0;
        len_setting     = srf_pkg::CFG_BITS'(srf_pkg::LEN_RESET);
        rank_setting    = srf_pkg::CFG_BITS'(srf_pkg::RANK_RESET);
        restart_window();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_register_saturation();
        test_rank_keeps_window();
        test_random_streams();
        settle();

        $display("summary: %0d samples sent, %0d ranked results checked, %0d mismatches",
                 samples_sent, results_checked, mismatch_count);
        $display("summary: %0d register writes, lengths 1 to 64 and ranks 1 to 64 with saturation",
                 settings_used);
        if (mismatch_count == 0 && expected_ranked.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
